@@ hw/rtl/ray_obb_slab_test_assert.svh @@
// Assertion macros shared by the ray/box slab test RTL.
// Used by files that expect clk_i and rst_ni in scope.
`ifndef RAY_OBB_SLAB_TEST_ASSERT_SVH
`define RAY_OBB_SLAB_TEST_ASSERT_SVH

// Check a property outside reset.
`define ROST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ROST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/rost_pkg.sv @@
// Shared constants, types and width helpers for the ray/box slab test.
// No dependencies.
package rost_pkg;

  localparam int COMPONENT_BITS_DEF = 21;
  localparam int FRACTION_BITS_DEF  = 12;
  localparam int PACK_W             = 63;
  localparam int LEN_W              = 20;
  localparam int AXES               = 3;
  localparam int QUEUE_DEPTH        = 4;

  typedef enum logic [1:0] {
    KIND_BOX     = 2'd0,
    KIND_SPHERE  = 2'd1,
    KIND_CAPSULE = 2'd2
  } kind_e;

  // Per-item status that travels from the front end to the back end
  typedef struct packed {
    logic       kind_miss;
    logic [2:0] par;
    logic [2:0] par_miss;
  } flags_t;

  // Axis component width: must hold the unit value used for spheres
  function automatic int a_w(int cb, int fb);
    return (cb > fb + 1) ? cb : fb + 2;
  endfunction

  function automatic int e_w(int cb, int fb);
    return a_w(cb, fb) + cb + 3;
  endfunction

  function automatic int dp_w(int cb, int fb);
    return a_w(cb, fb) + cb + 2;
  endfunction

  function automatic int m_w(int cb, int fb);
    return dp_w(cb, fb) + LEN_W + 1;
  endfunction

  function automatic int den_w(int cb, int fb);
    return m_w(cb, fb) - fb;
  endfunction

  function automatic int num_w(int cb, int fb);
    return ((e_w(cb, fb) > cb + fb) ? e_w(cb, fb) : cb + fb) + 1;
  endfunction

  // Numerator scaled by 2^fb ahead of the divide
  function automatic int nsw(int cb, int fb);
    return num_w(cb, fb) + fb;
  endfunction

endpackage

@@ hw/rtl/rost_front.sv @@
// Front end: accepts items, projects offsets and direction per axis,
// and classifies parallel axes. Depends on rost_pkg.
module rost_front #(
  parameter int CB = rost_pkg::COMPONENT_BITS_DEF,
  parameter int FB = rost_pkg::FRACTION_BITS_DEF,
  localparam int FW  = rost_pkg::den_w(CB, FB),
  localparam int NSW = rost_pkg::nsw(CB, FB)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [rost_pkg::PACK_W-1:0]    centre_i,
  input  logic [rost_pkg::PACK_W-1:0]    axis_one_i,
  input  logic [rost_pkg::PACK_W-1:0]    axis_two_i,
  input  logic [rost_pkg::PACK_W-1:0]    axis_three_i,
  input  logic [rost_pkg::PACK_W-1:0]    half_sizes_i,
  input  logic [rost_pkg::PACK_W-1:0]    ray_start_i,
  input  logic [rost_pkg::PACK_W-1:0]    ray_dir_i,
  input  logic [rost_pkg::LEN_W-1:0]     ray_length_i,
  input  logic                           full_i,
  output logic                           push_o,
  output logic [3*NSW-1:0]               num0_o,
  output logic [3*NSW-1:0]               num1_o,
  output logic [3*FW-1:0]                den_o,
  output rost_pkg::flags_t               flags_o
);

  localparam int AW  = rost_pkg::a_w(CB, FB);
  localparam int DW  = CB + 1;
  localparam int PEW = AW + DW;
  localparam int PDW = AW + CB;
  localparam int EW  = rost_pkg::e_w(CB, FB);
  localparam int DPW = rost_pkg::dp_w(CB, FB);
  localparam int MW  = rost_pkg::m_w(CB, FB);
  localparam int NW  = rost_pkg::num_w(CB, FB);
  localparam int LW  = rost_pkg::LEN_W;

  logic en;
  logic va_q, vb_q, vc_q, vd_q;

  // Stage A: unpack, subtract start from centre, pick axes
  logic [rost_pkg::PACK_W-1:0] axis_v [3];
  logic signed [DW-1:0] d_d   [3];
  logic signed [DW-1:0] d_q   [3];
  logic signed [AW-1:0] a_d   [3][3];
  logic signed [AW-1:0] a_q   [3][3];
  logic signed [CB-1:0] dir_d [3];
  logic signed [CB-1:0] dir_q [3];
  logic signed [CB-1:0] hs_d  [3];
  logic signed [CB-1:0] hs_a_q [3];
  logic [LW-1:0]        len_a_q;
  logic                 km_a_q;
  logic signed [AW-1:0] unit_s;

  assign axis_v[0] = axis_one_i;
  assign axis_v[1] = axis_two_i;
  assign axis_v[2] = axis_three_i;
  assign unit_s    = AW'(1) << FB;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k]   = DW'($signed(centre_i[k*CB +: CB])) - DW'($signed(ray_start_i[k*CB +: CB]));
      dir_d[k] = $signed(ray_dir_i[k*CB +: CB]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (kind_i == rost_pkg::KIND_BOX) begin
          a_d[i][k] = AW'($signed(axis_v[i][k*CB +: CB]));
        end else begin
          a_d[i][k] = (i == k) ? unit_s : '0;
        end
      end
      hs_d[i] = (kind_i == rost_pkg::KIND_BOX) ? $signed(half_sizes_i[i*CB +: CB])
                                                : $signed(half_sizes_i[CB-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= d_d;
      a_q     <= a_d;
      dir_q   <= dir_d;
      hs_a_q  <= hs_d;
      len_a_q <= ray_length_i;
      km_a_q  <= kind_i[1];
    end
  end

  // Stage B: per-axis products
  logic signed [PEW-1:0] pe_d [3][3];
  logic signed [PEW-1:0] pe_q [3][3];
  logic signed [PDW-1:0] pd_d [3][3];
  logic signed [PDW-1:0] pd_q [3][3];
  logic signed [CB-1:0]  hs_b_q [3];
  logic [LW-1:0]         len_b_q;
  logic                  km_b_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pe_d[i][k] = PEW'(a_q[i][k]) * PEW'(d_q[k]);
        pd_d[i][k] = PDW'(a_q[i][k]) * PDW'(dir_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_q    <= pe_d;
      pd_q    <= pd_d;
      hs_b_q  <= hs_a_q;
      len_b_q <= len_a_q;
      km_b_q  <= km_a_q;
    end
  end

  // Stage C: dot-product sums
  logic signed [EW-1:0]  e_d  [3];
  logic signed [EW-1:0]  e_c_q [3];
  logic signed [DPW-1:0] dp_d [3];
  logic signed [DPW-1:0] dp_q [3];
  logic signed [CB-1:0]  hs_c_q [3];
  logic [LW-1:0]         len_c_q;
  logic                  km_c_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_d[i]  = EW'(pe_q[i][0]) + EW'(pe_q[i][1]) + EW'(pe_q[i][2]);
      dp_d[i] = DPW'(pd_q[i][0]) + DPW'(pd_q[i][1]) + DPW'(pd_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_c_q   <= e_d;
      dp_q    <= dp_d;
      hs_c_q  <= hs_b_q;
      len_c_q <= len_b_q;
      km_c_q  <= km_b_q;
    end
  end

  // Stage D: scale direction projection by the ray length
  logic signed [MW-1:0] m_d [3];
  logic signed [MW-1:0] m_q [3];
  logic signed [EW-1:0] e_d_q [3];
  logic signed [CB-1:0] hs_d_q [3];
  logic                 km_d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i] = MW'(dp_q[i]) * MW'($signed({1'b0, len_c_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      e_d_q  <= e_c_q;
      hs_d_q <= hs_c_q;
      km_d_q <= km_c_q;
    end
  end

  // Advance all stages together; hold when the queue cannot take the last one
  assign en         = !(vd_q && full_i);
  assign in_ready_o = en;
  assign push_o     = vd_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Classify axes and form slab numerators for the queue
  logic signed [FW-1:0] f_v   [3];
  logic signed [FW-1:0] s_f;
  logic signed [NW-1:0] hsc   [3];
  logic signed [NW-1:0] lo    [3];
  logic signed [NW-1:0] hi    [3];

  assign s_f = FW'(1) << FB;

  always_comb begin
    flags_o.kind_miss = km_d_q;
    for (int i = 0; i < 3; i++) begin
      f_v[i]             = FW'(m_q[i] >>> FB);
      hsc[i]             = NW'(hs_d_q[i]) <<< FB;
      lo[i]              = NW'(e_d_q[i]) - hsc[i];
      hi[i]              = NW'(e_d_q[i]) + hsc[i];
      flags_o.par[i]      = (f_v[i] < s_f) && (f_v[i] > -s_f);
      flags_o.par_miss[i] = (hi[i] < 0) || (lo[i] > 0);
      num0_o[i*NSW +: NSW] = NSW'(lo[i]) <<< FB;
      num1_o[i*NSW +: NSW] = NSW'(hi[i]) <<< FB;
      den_o[i*FW +: FW]    = f_v[i];
    end
  end

endmodule

@@ hw/rtl/rost_fifo.sv @@
// Short register queue between the front and back ends.
// No dependencies.
module rost_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/rost_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, saturating,
// rounding toward zero. Depends on nothing.
module rost_div #(
  parameter int NSW = 60,
  parameter int FW  = 40,
  parameter int CB  = 21
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [NSW-1:0] num_i,
  input  logic signed [FW-1:0]  den_i,
  output logic signed [CB-1:0]  t_o
);

  // Quotient bits: CB+1 magnitude bits plus an overflow bit on top
  localparam int QB = CB + 1;
  localparam int MB = QB + 1;
  localparam int UW = ((NSW > FW + QB) ? NSW : FW + QB) + 1;

  logic [UW-1:0] rem_q [QB+2];
  logic [UW-1:0] dv_q  [QB+2];
  logic [MB-1:0] mag_q [QB+2];
  logic          neg_q [QB+2];

  // Take magnitudes and the result sign
  logic signed [UW-1:0] num_x, den_x;
  assign num_x = UW'(num_i);
  assign den_x = UW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_x[UW-1] ? UW'(-num_x) : UW'(num_x);
      dv_q[0]  <= den_x[UW-1] ? UW'(-den_x) : UW'(den_x);
      mag_q[0] <= '0;
      neg_q[0] <= num_i[NSW-1] ^ den_i[FW-1];
    end
  end

  // One compare and subtract per stage, most significant bit first
  for (genvar s = 1; s <= QB + 1; s++) begin : g_stage
    localparam int J = QB + 1 - s;
    logic [UW-1:0] sh;
    logic          ge;
    assign sh = dv_q[s-1] << J;
    assign ge = rem_q[s-1] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_q[s-1] - sh : rem_q[s-1];
        dv_q[s]  <= dv_q[s-1];
        mag_q[s] <= mag_q[s-1] | (MB'(ge) << J);
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // Saturate to the signed component range
  localparam logic [MB-1:0] LIM_NEG = MB'(1) << (CB - 1);
  localparam logic [MB-1:0] LIM_POS = LIM_NEG - 1'b1;
  localparam logic [CB-1:0] T_HIGH  = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] T_LOW   = {1'b1, {(CB-1){1'b0}}};

  logic [MB-1:0] mag;
  logic [CB-1:0] t_d;
  assign mag = mag_q[QB+1];

  always_comb begin
    if (neg_q[QB+1]) begin
      t_d = (mag > LIM_NEG) ? T_LOW : CB'(MB'(0) - mag);
    end else begin
      t_d = (mag > LIM_POS) ? T_HIGH : CB'(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o <= t_d;
    end
  end

endmodule

@@ hw/rtl/rost_back.sv @@
// Back end: slab parameter division, range narrowing and output register.
// Depends on rost_pkg and rost_div.
module rost_back #(
  parameter int CB = rost_pkg::COMPONENT_BITS_DEF,
  parameter int FB = rost_pkg::FRACTION_BITS_DEF,
  localparam int FW  = rost_pkg::den_w(CB, FB),
  localparam int NSW = rost_pkg::nsw(CB, FB)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic [3*NSW-1:0]    num0_i,
  input  logic [3*NSW-1:0]    num1_i,
  input  logic [3*FW-1:0]     den_i,
  input  rost_pkg::flags_t    flags_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o
);

  // Divider stages: magnitude stage, CB+2 bit stages, saturate stage
  localparam int LAT = CB + 4;
  localparam logic signed [CB-1:0] T_HIGH = {1'b0, {(CB-1){1'b1}}};

  logic en;
  logic out_valid_q, out_valid_d;
  logic hit_q, hit_d;
  logic v_q [LAT];
  rost_pkg::flags_t fl_q [LAT];
  logic signed [CB-1:0] t0 [3];
  logic signed [CB-1:0] t1 [3];

  // Move when the output register is free or being emptied
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rost_div #(.NSW(NSW), .FW(FW), .CB(CB)) u_div0 (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num0_i[i*NSW +: NSW]),
      .den_i (den_i[i*FW +: FW]),
      .t_o   (t0[i])
    );
    rost_div #(.NSW(NSW), .FW(FW), .CB(CB)) u_div1 (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num1_i[i*NSW +: NSW]),
      .den_i (den_i[i*FW +: FW]),
      .t_o   (t1[i])
    );
  end

  // Carry valid and flags alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= pop_o;
      for (int s = 1; s < LAT; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= flags_i;
      for (int s = 1; s < LAT; s++) begin
        fl_q[s] <= fl_q[s-1];
      end
    end
  end

  // Narrow [tmin, tmax] axis by axis; reject on crossing or any miss flag
  logic signed [CB-1:0] tmin, tmax, lo, hi;
  logic                 ok;
  rost_pkg::flags_t     fl;
  assign fl = fl_q[LAT-1];

  always_comb begin
    tmin = '0;
    tmax = T_HIGH;
    ok   = !fl.kind_miss;
    for (int i = 0; i < 3; i++) begin
      lo = (t0[i] > t1[i]) ? t1[i] : t0[i];
      hi = (t0[i] > t1[i]) ? t0[i] : t1[i];
      if (fl.par[i]) begin
        if (fl.par_miss[i]) begin
          ok = 1'b0;
        end
      end else begin
        if (lo > tmin) begin
          tmin = lo;
        end
        if (hi < tmax) begin
          tmax = hi;
        end
        if ((tmin > tmax) || (tmax < 0)) begin
          ok = 1'b0;
        end
      end
    end
    hit_d       = ok && (tmax > 0);
    out_valid_d = en ? v_q[LAT-1] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

@@ hw/rtl/ray_obb_slab_test.sv @@
// Top level of the ray versus oriented box / sphere slab test.
// Depends on rost_pkg, rost_front, rost_fifo, rost_back and the assert header.
//
//   channel  signals                       direction  moves
//   in       in_valid_i / in_ready_o       sink       one ray + collider
//   out      out_valid_o / out_ready_i     source     one hit bit
//
// One item per cycle sustained while out_ready_i is high; path: 4 front
// stages, one queue slot, COMPONENT_BITS+4 divider stages, output register.
// The per-axis restoring dividers, one quotient bit per stage, set the depth.
// Reset clears all valid flags and the queue; no clearing pass.
// An output stall backs up the back end only; the front keeps taking items
// until the queue of QUEUE_DEPTH entries is full.
module ray_obb_slab_test #(
  parameter int COMPONENT_BITS = rost_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = rost_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [rost_pkg::PACK_W-1:0]   centre_i,
  input  logic [rost_pkg::PACK_W-1:0]   axis_one_i,
  input  logic [rost_pkg::PACK_W-1:0]   axis_two_i,
  input  logic [rost_pkg::PACK_W-1:0]   axis_three_i,
  input  logic [rost_pkg::PACK_W-1:0]   half_sizes_i,
  input  logic [rost_pkg::PACK_W-1:0]   ray_start_i,
  input  logic [rost_pkg::PACK_W-1:0]   ray_dir_i,
  input  logic [rost_pkg::LEN_W-1:0]    ray_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);

  `include "ray_obb_slab_test_assert.svh"

  localparam int FW  = rost_pkg::den_w(COMPONENT_BITS, FRACTION_BITS);
  localparam int NSW = rost_pkg::nsw(COMPONENT_BITS, FRACTION_BITS);
  localparam int FLW = $bits(rost_pkg::flags_t);
  localparam int QW  = 6 * NSW + 3 * FW + FLW;

  logic             push, pop, full, empty;
  logic [3*NSW-1:0] num0_f, num1_f, num0_b, num1_b;
  logic [3*FW-1:0]  den_f, den_b;
  rost_pkg::flags_t flags_f, flags_b;
  logic [QW-1:0]    q_in, q_out;

  rost_front #(.CB(COMPONENT_BITS), .FB(FRACTION_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .centre_i     (centre_i),
    .axis_one_i   (axis_one_i),
    .axis_two_i   (axis_two_i),
    .axis_three_i (axis_three_i),
    .half_sizes_i (half_sizes_i),
    .ray_start_i  (ray_start_i),
    .ray_dir_i    (ray_dir_i),
    .ray_length_i (ray_length_i),
    .full_i       (full),
    .push_o       (push),
    .num0_o       (num0_f),
    .num1_o       (num1_f),
    .den_o        (den_f),
    .flags_o      (flags_f)
  );

  // Pack the front result for the queue and unpack on the far side
  assign q_in = {num0_f, num1_f, den_f, flags_f};
  assign {num0_b, num1_b, den_b, flags_b} = q_out;

  rost_fifo #(.WIDTH(QW), .DEPTH(rost_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (empty)
  );

  rost_back #(.CB(COMPONENT_BITS), .FB(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .num0_i      (num0_b),
    .num1_i      (num1_b),
    .den_i       (den_b),
    .flags_i     (flags_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o)
  );

  `ROST_ASSERT(a_no_overflow, push |-> !full, "queue written while full")
  `ROST_ASSERT(a_no_underflow, pop |-> !empty, "queue read while empty")
  `ROST_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> (!out_valid_o && empty), "busy in reset")

endmodule
